[rtl/shfnv_pkg.sv]
// ----------------------------------------------------------------------------
// shfnv_pkg
// Shared constants and helpers for the simhash engine: the FNV-1a 128-bit
// offset basis, the prime multiply and the hash-bit to counter mapping.
// ----------------------------------------------------------------------------
package shfnv_pkg;

    localparam int HASH_W    = 128;
    localparam int NUM_CTR   = 128;
    localparam int BYTE_W    = 8;
    localparam int OUT_HALF  = 64;

    // multiplier is 2^88 + 0x13b
    localparam logic [8:0] PRIME_LOW     = 9'h13B;
    localparam int         FNV_SHIFT_HI  = 64 + 24;

    localparam logic [HASH_W-1:0] FNV_BASIS =
        {32'h6C62272E, 32'h07BB0142, 32'h62B82175, 32'h6295C58D};

    typedef logic [HASH_W-1:0] hash_t;

    // hash times the prime, modulo 2^128, as shifted adds
    function automatic hash_t fnv_mul(input hash_t x);
        hash_t acc;
        acc = '0;
        for (int b = 0; b < 9; b++)
        begin
            if (PRIME_LOW[b])
            begin
                acc = acc + (x << b);
            end
        end
        fnv_mul = acc + (x << FNV_SHIFT_HI);
    endfunction

    // hash bit that feeds counter c; big selects the reversed byte layout
    // counter c = 8m + j takes bit 7-j of byte m, byte 4i+k is bits 8k.. of word i
    function automatic logic [6:0] hash_bit_idx(input logic [6:0] c, input logic big);
        logic [3:0] m;
        logic [2:0] j;
        m = big ? ~c[6:3] : c[6:3];
        j = c[2:0];
        hash_bit_idx = {~m[3:2], m[1:0], ~j};
    endfunction

endpackage

[rtl/simhash_fnv1a128_engine.sv]
// ----------------------------------------------------------------------------
// simhash_fnv1a128_engine
// Streaming simhash over token bytes, each token hashed with 128-bit FNV-1a
// and folded into 128 saturating signed counters.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tdata token_byte, tlast token_end,
//                                          tuser doc_end
//  m_*       out        m_tvalid/m_tready  tdata simhash_high, simhash_low
//  cfg_*     in         cfg_valid/ready    cfg_data word_order_big
//
//  one item per cycle while s_tready is high; the hash updates at the input,
//  the finished token hash is registered into the tally stage where the
//  counters update, and a document result then goes to the output register
//  s_tready drops only while a document end waits in the tally stage and
//  the output register still holds an untaken result
//  rst_n restores the offset basis, clears all counters and word_order_big
//
module simhash_fnv1a128_engine #(
    parameter int COUNTER_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // slave side
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] token_byte
    input  logic         s_tlast,    // token_end
    input  logic         s_tuser,    // doc_end
    // master side
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,    // [63:0] simhash_high, [127:64] simhash_low
    // configuration
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_data    // word_order_big
);

    import shfnv_pkg::*;

    localparam logic signed [COUNTER_BITS-1:0] CTR_MAX = {1'b0, {(COUNTER_BITS-1){1'b1}}};
    localparam logic signed [COUNTER_BITS-1:0] CTR_MIN = {1'b1, {(COUNTER_BITS-1){1'b0}}};

    logic                            word_order_reg;
    hash_t                           hash_reg;
    hash_t                           hash_mul;
    logic                            tok_valid_reg;
    logic                            tok_doc_reg;
    hash_t                           tok_hash_reg;
    logic signed [COUNTER_BITS-1:0]  tally_reg  [NUM_CTR];
    logic signed [COUNTER_BITS-1:0]  tally_next [NUM_CTR];
    logic [NUM_CTR-1:0]              pos_bits;
    logic [HASH_W-1:0]               sim_next;
    logic                            out_valid_reg;
    logic [HASH_W-1:0]               out_data_reg;
    logic                            in_fire;
    logic                            tok_advance;
    logic                            tok_fire;
    logic                            doc_fire;

    // handshakes
    assign cfg_ready   = 1'b1;
    assign tok_advance = !tok_doc_reg || !out_valid_reg || m_tready;
    assign tok_fire    = tok_valid_reg && tok_advance;
    assign doc_fire    = tok_fire && tok_doc_reg;
    assign s_tready    = !tok_valid_reg || tok_advance;
    assign in_fire     = s_tvalid && s_tready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_order_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            word_order_reg <= cfg_data[0];
        end
    end

    // running hash: xor the byte in, multiply by the prime
    assign hash_mul = fnv_mul(hash_reg ^ HASH_W'(s_tdata));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else if (in_fire)
        begin
            hash_reg <= s_tlast ? FNV_BASIS : hash_mul;
        end
    end

    // tally stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
            tok_doc_reg   <= 1'b0;
        end
        else if (in_fire && s_tlast)
        begin
            tok_valid_reg <= 1'b1;
            tok_doc_reg   <= s_tuser;
        end
        else if (tok_advance)
        begin
            tok_valid_reg <= 1'b0;
            tok_doc_reg   <= 1'b0;
        end
    end

    // finished token hash
    always_ff @(posedge clk)
    begin
        if (in_fire && s_tlast)
        begin
            tok_hash_reg <= hash_mul;
        end
    end

    // saturating counter updates and sign test, all counters in parallel
    always_comb
    begin
        for (int c = 0; c < NUM_CTR; c++)
        begin
            if (tok_hash_reg[hash_bit_idx(7'(c), word_order_reg)])
            begin
                tally_next[c] = (tally_reg[c] == CTR_MAX) ? CTR_MAX : tally_reg[c] + 1'b1;
            end
            else
            begin
                tally_next[c] = (tally_reg[c] == CTR_MIN) ? CTR_MIN : tally_reg[c] - 1'b1;
            end
            pos_bits[c] = !tally_next[c][COUNTER_BITS-1] && (tally_next[c] != '0);
            sim_next[HASH_W-1-c] = pos_bits[c];
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CTR; c++)
            begin
                tally_reg[c] <= '0;
            end
        end
        else if (tok_fire)
        begin
            for (int c = 0; c < NUM_CTR; c++)
            begin
                tally_reg[c] <= tok_doc_reg ? '0 : tally_next[c];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (doc_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (doc_fire)
        begin
            out_data_reg <= sim_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg[OUT_HALF-1:0], out_data_reg[HASH_W-1:OUT_HALF]};

    // checks
    a_doc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        doc_fire |=> m_tvalid)
        else $error("document end did not load a result");

    a_token_restarts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=> (hash_reg == FNV_BASIS))
        else $error("hash not restarted after token end");

    a_doc_clears_tally: assert property (@(posedge clk) disable iff (!rst_n)
        doc_fire |=> (tally_reg[0] == '0) && (tally_reg[NUM_CTR-1] == '0))
        else $error("counters not cleared after document end");

    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (tok_valid_reg && tok_doc_reg && m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");

endmodule
